// ===== hw/rtl/vvpwm_pkg.sv =====
// shared constants for the voltage vector to phase pwm block
// sine polynomial coefficients, sqrt(3) and default parameter values; no dependencies
package vvpwm_pkg;

  localparam int unsigned PWM_TOP_DEF    = 3300;
  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned SUPPLY_W       = 16;
  localparam int unsigned PHASE_W        = 24;

  localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 16'd12000;

  localparam logic [14:0] SIN_A     = 15'd25736;
  localparam logic [13:0] SIN_B     = 14'd10512;
  localparam logic [10:0] SIN_C     = 11'd1160;
  localparam logic [14:0] SQRT3_Q14 = 15'd28378;

endpackage

// ===== hw/rtl/voltage_vector_to_phase_pwm.sv =====
// voltage vector to three-phase pwm compare values: clamp, inverse park/clarke, scaling
// depends on vvpwm_pkg
//
// Takes a signed quadrature voltage demand (mV) and an electrical angle and returns
// three pwm compare values, one result per input transfer. The block keeps no state
// between items and accepts one transfer every clock cycle unless output back-pressure
// has filled the pipeline. The pipeline holds the sine polynomial stages, the
// multiplier stages and the restoring divider by the supply voltage, which resolves
// one quotient bit per stage. Each stage moves on its own when the next one is free,
// so bubbles close up under output back-pressure. supply_voltage sits at byte
// address 0 of the config port and must be written only while idle; the block itself
// does not enforce this. A zero supply gives all-zero compare values.
module voltage_vector_to_phase_pwm #(
  parameter int unsigned PWM_TOP    = vvpwm_pkg::PWM_TOP_DEF,
  parameter int unsigned ANGLE_BITS = vvpwm_pkg::ANGLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // voltage_demand[15:0], electrical_angle[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // compare_a[11:0], compare_b[23:12], compare_c[35:24]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned QW  = $clog2(PWM_TOP + 1);
  localparam int unsigned SW  = vvpwm_pkg::SUPPLY_W;
  localparam int unsigned NW  = SW + QW;
  localparam int unsigned NS  = 9 + QW;
  localparam int unsigned ASH = vvpwm_pkg::PHASE_W - ANGLE_BITS;
  localparam logic [23:0] AMASK = 24'((64'd1 << ANGLE_BITS) - 64'd1);

  // config register
  logic [SW-1:0] supply_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'b0, supply_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= vvpwm_pkg::SUPPLY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      supply_q <= pwdata[SW-1:0];
    end
  end

  // valid chain with per-stage ready
  logic [NS-1:0] vld_q;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NS-1];

  // stage 0: demand clamp, phase and quadrant fold (lane 0 sine, lane 1 cosine)
  logic signed [15:0] dem;
  logic signed [17:0] u2w, sup_s, u2_d;
  logic [23:0]        phase;
  logic [1:0]         quad_d [2];
  logic [14:0]        x_d [2];
  logic [22:0]        rr [2];

  always_comb begin
    dem   = $signed(s_axis_tdata[15:0]);
    u2w   = $signed({dem[15], dem, 1'b0});
    sup_s = $signed({2'b0, supply_q});
    if (u2w > sup_s) begin
      u2_d = sup_s;
    end else if (u2w < -sup_s) begin
      u2_d = -sup_s;
    end else begin
      u2_d = u2w;
    end
    phase     = 24'(({8'b0, s_axis_tdata[31:16]} & AMASK) << ASH);
    quad_d[0] = phase[23:22];
    quad_d[1] = 2'(phase[23:22] + 2'd1);
    for (int i = 0; i < 2; i++) begin
      rr[i]  = quad_d[i][0] ? 23'(23'h400000 - {1'b0, phase[21:0]}) : {1'b0, phase[21:0]};
      x_d[i] = 15'(rr[i] >> 8);
    end
  end

  logic signed [17:0] u2_q0, u2_q1, u2_q2, u2_q3, u2_q4, u2_q5;
  logic [1:0]         quad_q0 [2], quad_q1 [2], quad_q2 [2], quad_q3 [2];
  logic [14:0]        x_q0 [2], x_q1 [2], x_q2 [2], x_q3 [2];
  logic [14:0]        x2_q1 [2], x2_q2 [2];
  logic [13:0]        t2_q2 [2];
  logic [14:0]        t4_q3 [2];
  logic signed [15:0] sc_q4 [2];

  logic [14:0]        x2_d [2];
  logic [10:0]        t1 [2];
  logic [13:0]        t2_d [2];
  logic [13:0]        t3 [2];
  logic [14:0]        t4_d [2];
  logic [14:0]        t5 [2];
  logic signed [15:0] sc_d [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      x2_d[i] = 15'((30'(x_q0[i]) * 30'(x_q0[i])) >> 14);
      t1[i]   = 11'((26'(vvpwm_pkg::SIN_C) * 26'(x2_q1[i])) >> 14);
      t2_d[i] = 14'(vvpwm_pkg::SIN_B - 14'(t1[i]));
      t3[i]   = 14'((29'(t2_q2[i]) * 29'(x2_q2[i])) >> 14);
      t4_d[i] = 15'(vvpwm_pkg::SIN_A - 15'(t3[i]));
      t5[i]   = 15'((30'(x_q3[i]) * 30'(t4_q3[i])) >> 14);
      sc_d[i] = quad_q3[i][1] ? -$signed({1'b0, t5[i]}) : $signed({1'b0, t5[i]});
    end
  end

  // stage 5..7: rotation products, phase sums and clamp
  logic signed [33:0] p_d, p_q5, p_q6;
  logic signed [31:0] cs3_d, cs3_q5;
  logic signed [49:0] q_d, q_q6;
  logic [45:0]        v_d [3];
  logic [45:0]        v_q7 [3];
  logic signed [51:0] mid, full, pa, va, vb, vc;

  function automatic logic [45:0] clamp_v(logic signed [51:0] v, logic signed [51:0] f);
    logic [45:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > f) begin
      r = 46'(f);
    end else begin
      r = 46'(v);
    end
    return r;
  endfunction

  always_comb begin
    p_d   = 34'(u2_q4) * 34'(sc_q4[0]);
    cs3_d = 32'(sc_q4[1]) * $signed({17'b0, vvpwm_pkg::SQRT3_Q14});
    q_d   = 50'(u2_q5) * 50'(cs3_q5);
    mid   = $signed(52'(supply_q) << 29);
    full  = $signed(52'(supply_q) << 30);
    pa    = 52'(p_q6) <<< 14;
    va    = mid - (pa <<< 1);
    vb    = mid + 52'(q_q6) + pa;
    vc    = mid - 52'(q_q6) + pa;
    v_d[0] = clamp_v(va, full);
    v_d[1] = clamp_v(vb, full);
    v_d[2] = clamp_v(vc, full);
  end

  // divider: remainder and quotient per stage and phase
  logic [NW-1:0] rem_q [QW+1][3];
  logic [QW-1:0] quo_q [QW+1][3];
  logic [NW-1:0] n_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_d[i] = NW'((62'(v_q7[i]) * 62'(PWM_TOP)) >> 30);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      u2_q0 <= u2_d;
      quad_q0 <= quad_d;
      x_q0 <= x_d;
    end
    if (rdy[1]) begin
      u2_q1 <= u2_q0;
      quad_q1 <= quad_q0;
      x_q1 <= x_q0;
      x2_q1 <= x2_d;
    end
    if (rdy[2]) begin
      u2_q2 <= u2_q1;
      quad_q2 <= quad_q1;
      x_q2 <= x_q1;
      x2_q2 <= x2_q1;
      t2_q2 <= t2_d;
    end
    if (rdy[3]) begin
      u2_q3 <= u2_q2;
      quad_q3 <= quad_q2;
      x_q3 <= x_q2;
      t4_q3 <= t4_d;
    end
    if (rdy[4]) begin
      u2_q4 <= u2_q3;
      sc_q4 <= sc_d;
    end
    if (rdy[5]) begin
      u2_q5 <= u2_q4;
      p_q5 <= p_d;
      cs3_q5 <= cs3_d;
    end
    if (rdy[6]) begin
      p_q6 <= p_q5;
      q_q6 <= q_d;
    end
    if (rdy[7]) begin
      v_q7 <= v_d;
    end
    if (rdy[8]) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= n_d[i];
        quo_q[0][i] <= '0;
      end
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [NW-1:0] dsv;
    assign dsv = NW'(supply_q) << (QW - j);
    always_ff @(posedge clk_i) begin
      if (rdy[8+j]) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_q[j-1][i] >= dsv) begin
            rem_q[j][i] <= rem_q[j-1][i] - dsv;
            quo_q[j][i] <= quo_q[j-1][i] | (QW'(1) << (QW - j));
          end else begin
            rem_q[j][i] <= rem_q[j-1][i];
            quo_q[j][i] <= quo_q[j-1][i];
          end
        end
      end
    end
  end

  logic [11:0] cmp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmp[i] = (supply_q == '0) ? 12'd0 : 12'(quo_q[QW][i]);
    end
  end

  assign m_axis_tdata = {4'b0, cmp[2], cmp[1], cmp[0]};

  zero_supply_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && supply_q == '0) |-> m_axis_tdata == '0)
    else $error("nonzero compare with zero supply");

  range_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && supply_q != '0) |->
      (quo_q[QW][0] <= PWM_TOP && quo_q[QW][1] <= PWM_TOP && quo_q[QW][2] <= PWM_TOP))
    else $error("compare above pwm top");

  ready_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule
